[rtl/convolution_3x3_abs_clamp_defines.svh]
// Assertion macros shared by the checker of the 3x3 convolution block.
// Needs a clock and a reset signal in the scope where a macro is used.
`ifndef CONVOLUTION_3X3_ABS_CLAMP_DEFINES_SVH
`define CONVOLUTION_3X3_ABS_CLAMP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CNV_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("convolution_3x3_abs_clamp: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CNV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("convolution_3x3_abs_clamp: assertion failed");

`endif

[rtl/cnv33_pkg.sv]
// Shared types, constants and helper functions of the 3x3 convolution block.
// No dependencies; imported by every file of the block but the macro header.
package cnv33_pkg;

   localparam int PIX_W          = 8;
   localparam int LINE_W         = 2 * PIX_W;
   localparam int CFG_SIZE_W     = 11;
   localparam int KERNEL_ROW_W   = 24;
   localparam int CSR_INDEX_W    = 3;
   localparam int TAG_POS_W      = 10;
   localparam int PROD_W         = 17;
   localparam int SUM_W          = 21;
   localparam int REQ_DATA_W     = 8;
   localparam int RSP_DATA_W     = 32;
   localparam int RSP_FIELD_W    = PIX_W + 2 * TAG_POS_W;
   localparam int RSP_PAD_W      = RSP_DATA_W - RSP_FIELD_W;
   localparam int RSP_FIFO_DEPTH = 8;
   localparam int MIN_SIZE       = 3;
   localparam int CLAMP_MAX      = 255;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_KERNEL_TOP    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_KERNEL_MIDDLE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;

   localparam logic [CFG_SIZE_W-1:0]   RST_FRAME_WIDTH   = 11'd1024;
   localparam logic [CFG_SIZE_W-1:0]   RST_FRAME_HEIGHT  = 11'd1024;
   localparam logic [KERNEL_ROW_W-1:0] RST_KERNEL_TOP    = 24'd0;
   localparam logic [KERNEL_ROW_W-1:0] RST_KERNEL_MIDDLE = 24'd256;
   localparam logic [KERNEL_ROW_W-1:0] RST_KERNEL_BOTTOM = 24'd0;

   typedef logic signed [PROD_W-1:0] prod_type;
   typedef prod_type [8:0]           prod_vec_type;

   typedef struct packed {
      logic [KERNEL_ROW_W-1:0] top_row;
      logic [KERNEL_ROW_W-1:0] middle_row;
      logic [KERNEL_ROW_W-1:0] bottom_row;
   } kernel_type;

   typedef struct packed {
      logic                 frame_end;
      logic [TAG_POS_W-1:0] row;
      logic [TAG_POS_W-1:0] column;
   } tag_type;

   typedef struct packed {
      logic                 frame_end;
      logic [TAG_POS_W-1:0] row;
      logic [TAG_POS_W-1:0] column;
      logic [PIX_W-1:0]     pixel;
   } rsp_item_type;

   // Signed coefficient at position 0 (left), 1 (middle) or 2 (right)
   function automatic logic signed [PIX_W-1:0] coef(input logic [KERNEL_ROW_W-1:0] packed_row,
                                                    input int unsigned pos);
      logic [PIX_W-1:0] b;
      b = packed_row[pos*PIX_W +: PIX_W];
      return $signed(b);
   endfunction

   function automatic prod_type mul_px(input logic signed [PIX_W-1:0] c,
                                       input logic [PIX_W-1:0] px);
      logic signed [PIX_W:0] p;
      p = $signed({1'b0, px});
      return prod_type'(c) * prod_type'(p);
   endfunction

endpackage

[rtl/cnv33_line_mem.sv]
// Line memory: both line stores side by side in one word, one read and one write port.
// Read data registered; a write to the address being read is forwarded. Uses cnv33_pkg.
module cnv33_line_mem
   import cnv33_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_WIDTH
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [LINE_W-1:0]        rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [LINE_W-1:0]        wr_data
);

   logic [LINE_W-1:0] mem [DEPTH];
   logic [LINE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         // forward the word written in the same cycle
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/cnv33_window.sv]
// 3x3 window of the two previous columns plus the incoming column, and the nine products.
// Products are registered for the sum stage. Uses cnv33_pkg.
module cnv33_window
   import cnv33_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic               in_produce,
   input  tag_type            in_tag,
   input  logic [PIX_W-1:0]   pixel,
   input  logic [PIX_W-1:0]   above,
   input  logic [PIX_W-1:0]   above2,
   input  kernel_type         kernel,
   output logic               out_valid,
   output tag_type            out_tag,
   output prod_vec_type       out_prod
);

   // win: 0/3 top, 1/4 middle, 2/5 bottom; 0..2 oldest column
   logic [PIX_W-1:0] win_ff [6];
   logic             valid_ff;
   tag_type          tag_ff;
   prod_vec_type     prod_ff;
   prod_vec_type     prod_in;

   always_comb begin
      prod_in[0] = mul_px(coef(kernel.top_row, 0),    win_ff[0]);
      prod_in[1] = mul_px(coef(kernel.top_row, 1),    win_ff[3]);
      prod_in[2] = mul_px(coef(kernel.top_row, 2),    above2);
      prod_in[3] = mul_px(coef(kernel.middle_row, 0), win_ff[1]);
      prod_in[4] = mul_px(coef(kernel.middle_row, 1), win_ff[4]);
      prod_in[5] = mul_px(coef(kernel.middle_row, 2), above);
      prod_in[6] = mul_px(coef(kernel.bottom_row, 0), win_ff[2]);
      prod_in[7] = mul_px(coef(kernel.bottom_row, 1), win_ff[5]);
      prod_in[8] = mul_px(coef(kernel.bottom_row, 2), pixel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid && in_produce;
         if (in_valid) begin
            // advance the window by one column
            win_ff[0] <= win_ff[3];
            win_ff[1] <= win_ff[4];
            win_ff[2] <= win_ff[5];
            win_ff[3] <= above2;
            win_ff[4] <= above;
            win_ff[5] <= pixel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_produce) begin
         prod_ff <= prod_in;
         tag_ff  <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_prod  = prod_ff;

endmodule

[rtl/cnv33_sum.sv]
// Sum of the nine products, then absolute value and clamp to the pixel range.
// One register stage; the clamp feeds the result buffer. Uses cnv33_pkg.
module cnv33_sum
   import cnv33_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  tag_type       in_tag,
   input  prod_vec_type  in_prod,
   output logic          out_valid,
   output rsp_item_type  out_item
);

   logic                    valid_ff;
   tag_type                 tag_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [SUM_W-1:0] sum_in;
   logic signed [SUM_W-1:0] row_top;
   logic signed [SUM_W-1:0] row_mid;
   logic signed [SUM_W-1:0] row_bot;
   logic        [SUM_W-1:0] mag;

   always_comb begin
      row_top = SUM_W'(in_prod[0]) + SUM_W'(in_prod[1]) + SUM_W'(in_prod[2]);
      row_mid = SUM_W'(in_prod[3]) + SUM_W'(in_prod[4]) + SUM_W'(in_prod[5]);
      row_bot = SUM_W'(in_prod[6]) + SUM_W'(in_prod[7]) + SUM_W'(in_prod[8]);
      sum_in  = row_top + row_mid + row_bot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         sum_ff <= sum_in;
         tag_ff <= in_tag;
      end
   end

   always_comb begin
      mag = sum_ff[SUM_W-1] ? $unsigned(-sum_ff) : $unsigned(sum_ff);
      out_item.pixel     = (mag > SUM_W'(CLAMP_MAX)) ? PIX_W'(CLAMP_MAX) : mag[PIX_W-1:0];
      out_item.column    = tag_ff.column;
      out_item.row       = tag_ff.row;
      out_item.frame_end = tag_ff.frame_end;
   end

   assign out_valid = valid_ff;

endmodule

[rtl/cnv33_rsp_fifo.sv]
// Result buffer between the fixed-latency pipeline and the result channel.
// Space is reserved upstream, so a push always finds a free entry. Uses cnv33_pkg.
module cnv33_rsp_fifo
   import cnv33_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  rsp_item_type  push_item,
   input  logic          pop,
   output logic          not_empty,
   output rsp_item_type  head_item
);

   localparam int PTR_W = $clog2(RSP_FIFO_DEPTH);
   localparam int CNT_W = $clog2(RSP_FIFO_DEPTH + 1);

   rsp_item_type     entry_ff [RSP_FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(RSP_FIFO_DEPTH - 1)) ? '0
                                                                    : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(RSP_FIFO_DEPTH - 1)) ? '0
                                                                    : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];

endmodule

[rtl/convolution_3x3_abs_clamp.sv]
// Top level of the 3x3 convolution with absolute value and clamp.
// Instantiates cnv33_line_mem, cnv33_window, cnv33_sum and cnv33_rsp_fifo; uses cnv33_pkg.
//
// Usage:
//   req_*: one 8-bit grayscale pixel per transaction in raster order; req_tuser high
//          marks column 0, row 0 of a frame. Positions wrap at the configured size,
//          so back-to-back frames need no marker.
//   rsp_*: one transaction per interior pixel: |sum of 3x3 products| clamped to 255,
//          with its column and row; rsp_tlast flags the last result of the frame.
//   csr_*: write-only registers (width, height, three kernel rows), written while idle.
// Throughput: one pixel per cycle while req_tready is high, set by the line memory, which
//   takes one read and one write each cycle (read at accept, shifted column written back
//   in the next cycle). Registers from accept to rsp_tvalid: stage after accept, products,
//   sum, result buffer.
// Stall: results queue in an 8-entry buffer; req_tready drops once eight results are
//   owed to the receiver, and the pipeline itself never halts.
// Reset (synchronous, active high): position counters, window and buffer cleared,
//   registers back to their defaults; line memory contents are not cleared.
module convolution_3x3_abs_clamp
   import cnv33_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,   // [7:0] pixel_in
   input  logic                    req_tuser,   // [0] frame_start
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,   // [7:0] pixel_out, [17:8] out_column,
                                                // [27:18] out_row, [31:28] zero
   output logic                    rsp_tlast,   // frame_end
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [KERNEL_ROW_W-1:0] csr_wdata
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int SW    = (CW + 1 > CFG_SIZE_W) ? CW + 1 : CFG_SIZE_W;
   localparam int HSW   = (RW + 1 > CFG_SIZE_W) ? RW + 1 : CFG_SIZE_W;
   localparam int CXW   = (CW > TAG_POS_W) ? CW : TAG_POS_W;
   localparam int RXW   = (RW > TAG_POS_W) ? RW : TAG_POS_W;
   localparam int PEND_W = $clog2(RSP_FIFO_DEPTH + 1);

   // configuration registers
   logic [CFG_SIZE_W-1:0]   frame_width_ff;
   logic [CFG_SIZE_W-1:0]   frame_height_ff;
   kernel_type              kernel_ff;

   // position counters and result credit
   logic [CW-1:0]     col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [PEND_W-1:0] pend_ff, pend_in;

   // stage after accept
   logic              a_valid_ff;
   logic              a_produce_ff;
   logic [PIX_W-1:0]  a_px_ff;
   logic [CW-1:0]     a_addr_ff;
   tag_type           a_tag_ff;

   logic              accept;
   logic              pop;
   logic [SW-1:0]     width_ext, width_sat, col_next;
   logic [HSW-1:0]    height_ext, height_sat, row_next;
   logic [CW-1:0]     col_eff;
   logic [RW-1:0]     row_eff;
   logic [CXW-1:0]    col_m1;
   logic [RXW-1:0]    row_m1;
   logic              row_wrap, frame_wrap, produce;
   tag_type           tag_new;

   logic [LINE_W-1:0] rd_data;
   logic [LINE_W-1:0] wr_data;
   logic              b_valid;
   tag_type           b_tag;
   prod_vec_type      b_prod;
   logic              push;
   rsp_item_type      push_item;
   logic              not_empty;
   rsp_item_type      head_item;

   assign accept = req_tvalid && req_tready;
   assign pop    = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff        <= RST_FRAME_WIDTH;
         frame_height_ff       <= RST_FRAME_HEIGHT;
         kernel_ff.top_row     <= RST_KERNEL_TOP;
         kernel_ff.middle_row  <= RST_KERNEL_MIDDLE;
         kernel_ff.bottom_row  <= RST_KERNEL_BOTTOM;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:   frame_width_ff       <= csr_wdata[CFG_SIZE_W-1:0];
            REG_FRAME_HEIGHT:  frame_height_ff      <= csr_wdata[CFG_SIZE_W-1:0];
            REG_KERNEL_TOP:    kernel_ff.top_row    <= csr_wdata;
            REG_KERNEL_MIDDLE: kernel_ff.middle_row <= csr_wdata;
            REG_KERNEL_BOTTOM: kernel_ff.bottom_row <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      // saturate the frame size to [3, MAX]
      width_ext = SW'(frame_width_ff);
      if (width_ext < SW'(MIN_SIZE)) begin
         width_sat = SW'(MIN_SIZE);
      end else if (width_ext > SW'(MAX_WIDTH)) begin
         width_sat = SW'(MAX_WIDTH);
      end else begin
         width_sat = width_ext;
      end
      height_ext = HSW'(frame_height_ff);
      if (height_ext < HSW'(MIN_SIZE)) begin
         height_sat = HSW'(MIN_SIZE);
      end else if (height_ext > HSW'(MAX_HEIGHT)) begin
         height_sat = HSW'(MAX_HEIGHT);
      end else begin
         height_sat = height_ext;
      end

      col_eff    = req_tuser ? '0 : col_ff;
      row_eff    = req_tuser ? '0 : row_ff;
      col_next   = SW'(col_eff) + SW'(1);
      row_next   = HSW'(row_eff) + HSW'(1);
      row_wrap   = (col_next >= width_sat);
      frame_wrap = (row_next >= height_sat);
      produce    = (col_eff >= CW'(2)) && (row_eff >= RW'(2));

      col_m1            = CXW'(col_eff) - CXW'(1);
      row_m1            = RXW'(row_eff) - RXW'(1);
      tag_new.column    = col_m1[TAG_POS_W-1:0];
      tag_new.row       = row_m1[TAG_POS_W-1:0];
      tag_new.frame_end = row_wrap && frame_wrap;

      col_in  = col_ff;
      row_in  = row_ff;
      if (accept) begin
         if (row_wrap) begin
            col_in = '0;
            row_in = frame_wrap ? '0 : row_next[RW-1:0];
         end else begin
            col_in = col_next[CW-1:0];
            row_in = row_eff;
         end
      end

      // reserve buffer space when a producing pixel is accepted, release it on delivery
      pend_in = pend_ff;
      if ((accept && produce) && !pop) begin
         pend_in = pend_ff + PEND_W'(1);
      end else if (pop && !(accept && produce)) begin
         pend_in = pend_ff - PEND_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         pend_ff    <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         pend_ff    <= pend_in;
         a_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_produce_ff <= produce;
         a_px_ff      <= req_tdata[PIX_W-1:0];
         a_addr_ff    <= col_eff;
         a_tag_ff     <= tag_new;
      end
   end

   assign req_tready = (pend_ff < PEND_W'(RSP_FIFO_DEPTH));

   // word: upper byte two rows above, lower byte row above; shift one row down
   assign wr_data = {rd_data[PIX_W-1:0], a_px_ff};

   cnv33_line_mem #(
      .DEPTH (MAX_WIDTH)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_eff),
      .rd_data (rd_data),
      .wr_en   (a_valid_ff),
      .wr_addr (a_addr_ff),
      .wr_data (wr_data)
   );

   cnv33_window u_window (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (a_valid_ff),
      .in_produce (a_produce_ff),
      .in_tag     (a_tag_ff),
      .pixel      (a_px_ff),
      .above      (rd_data[PIX_W-1:0]),
      .above2     (rd_data[LINE_W-1:PIX_W]),
      .kernel     (kernel_ff),
      .out_valid  (b_valid),
      .out_tag    (b_tag),
      .out_prod   (b_prod)
   );

   cnv33_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid),
      .in_tag    (b_tag),
      .in_prod   (b_prod),
      .out_valid (push),
      .out_item  (push_item)
   );

   cnv33_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .not_empty (not_empty),
      .head_item (head_item)
   );

   assign rsp_tvalid = not_empty;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, head_item.row, head_item.column, head_item.pixel};
   assign rsp_tlast  = head_item.frame_end;

endmodule

[rtl/cnv33_checker.sv]
// Port-level checker for the 3x3 convolution block, bound to its top level.
// Uses cnv33_pkg and the assertion macros of convolution_3x3_abs_clamp_defines.svh.
`include "convolution_3x3_abs_clamp_defines.svh"

module cnv33_checker
   import cnv33_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tlast
);

   logic [RSP_DATA_W:0] rsp_word;

   assign rsp_word = {rsp_tlast, rsp_tdata};

   // hold a stalled result transaction
   `CNV_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_word))

   // leave reset with an empty buffer and credit to accept
   `CNV_ASSERT_IMPL(a_reset_state, $fell(reset), req_tready && !rsp_tvalid)

   // a result into an empty buffer comes from a pixel accepted earlier
   `CNV_ASSERT_IMPL(a_rsp_latency, $rose(rsp_tvalid), $past(req_tvalid && req_tready, 4))

endmodule

bind convolution_3x3_abs_clamp cnv33_checker u_cnv33_checker (.*);

[verif/tb_convolution_3x3_abs_clamp.sv]
// Self-checking testbench of convolution_3x3_abs_clamp: drives raster pixel frames, predicts
// each clamped 3x3 result with its own line stores and window, and compares every result.
// Depends on cnv33_pkg and the RTL of the block only.
module tb_convolution_3x3_abs_clamp;
   import cnv33_pkg::*;

   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_PIXELS = 200;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    req_tuser = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [KERNEL_ROW_W-1:0] csr_wdata = '0;

   convolution_3x3_abs_clamp dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: registers as last written, two line stores, two window columns
   logic [CFG_SIZE_W-1:0]   cfg_width = RST_FRAME_WIDTH;
   logic [CFG_SIZE_W-1:0]   cfg_height = RST_FRAME_HEIGHT;
   logic [KERNEL_ROW_W-1:0] cfg_kernel [3] = '{RST_KERNEL_TOP, RST_KERNEL_MIDDLE,
                                               RST_KERNEL_BOTTOM};
   logic [PIX_W-1:0]        line_above [DEF_MAX_WIDTH] = '{default: '0};
   logic [PIX_W-1:0]        line_two_above [DEF_MAX_WIDTH] = '{default: '0};
   logic [PIX_W-1:0]        window [2][3] = '{default: '0};   // [oldest, newest][top..bottom]
   int unsigned             next_col = 0;
   int unsigned             next_row = 0;

   rsp_item_type pixels_due [$];
   int unsigned  pixels_accepted = 0;
   int unsigned  mismatch_count = 0;
   int unsigned  send_idle_pct = 22;
   int unsigned  recv_idle_pct = 72;

   function automatic int unsigned frame_dim(input logic [CFG_SIZE_W-1:0] reg_value,
                                             input int unsigned limit);
      if (reg_value < MIN_SIZE) return MIN_SIZE;
      if (reg_value > limit) return limit;
      return reg_value;
   endfunction

   function automatic logic [KERNEL_ROW_W-1:0] random_kernel_row();
      logic [KERNEL_ROW_W-1:0] coeffs;
      if ($urandom_range(2) == 0) return KERNEL_ROW_W'($urandom);
      // small coefficients keep many sums below the clamp
      for (int j = 0; j < 3; j++) coeffs[8*j +: 8] = 8'($urandom_range(4)) - 8'd2;
      return coeffs;
   endfunction

   task automatic convolve_pixel(input logic [PIX_W-1:0] px, input logic frame_first);
      int unsigned w, h, c, r, slot;
      logic [PIX_W-1:0] top, mid;
      logic [PIX_W-1:0] taps [3][3];
      int acc, coeff;
      rsp_item_type due;
      w = frame_dim(cfg_width, DEF_MAX_WIDTH);
      h = frame_dim(cfg_height, DEF_MAX_HEIGHT);
      if (frame_first) begin
         next_col = 0;
         next_row = 0;
      end
      c = next_col;
      r = next_row;
      slot = (c < DEF_MAX_WIDTH) ? c : DEF_MAX_WIDTH - 1;
      top = line_two_above[slot];
      mid = line_above[slot];
      if (c >= 2 && r >= 2) begin
         for (int i = 0; i < 3; i++) begin
            taps[i][0] = window[0][i];
            taps[i][1] = window[1][i];
         end
         taps[0][2] = top;
         taps[1][2] = mid;
         taps[2][2] = px;
         acc = 0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               coeff = $signed(cfg_kernel[i][8*j +: 8]);
               acc += coeff * int'(taps[i][j]);
            end
         end
         if (acc < 0) acc = -acc;
         due.pixel = (acc > CLAMP_MAX) ? PIX_W'(CLAMP_MAX) : PIX_W'(acc);
         due.column = TAG_POS_W'(c - 1);
         due.row = TAG_POS_W'(r - 1);
         due.frame_end = (c + 1 >= w) && (r + 1 >= h);
         pixels_due.push_back(due);
      end
      line_two_above[slot] = mid;
      line_above[slot] = px;
      window[0] = window[1];
      window[1] = '{top, mid, px};
      // wrap at the configured size, even when already beyond it
      if (c + 1 >= w) begin
         next_col = 0;
         next_row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         next_col = c + 1;
      end
   endtask

   task automatic send_pixel(input logic [PIX_W-1:0] px, input logic frame_first);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      req_tuser <= frame_first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      convolve_pixel(px, frame_first);
      pixels_accepted++;
      @(negedge clock);
   endtask

   task automatic send_frame(input int unsigned pixels, input logic marked,
                             input int unsigned lo, input int unsigned hi, input logic noisy);
      for (int unsigned k = 0; k < pixels; k++) begin
         send_pixel(PIX_W'($urandom_range(hi, lo)),
                    (k == 0 && marked) || (noisy && $urandom_range(199) == 0));
      end
   endtask

   // Hold the sender until every owed result is out, then let the pipeline empty
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pixels_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic apply_settings(input logic [CFG_SIZE_W-1:0] width_reg, height_reg,
                                 input logic [KERNEL_ROW_W-1:0] top_reg, mid_reg, bot_reg);
      logic [CSR_INDEX_W-1:0]  index [5];
      logic [KERNEL_ROW_W-1:0] value [5];
      index = '{REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_KERNEL_TOP, REG_KERNEL_MIDDLE,
                REG_KERNEL_BOTTOM};
      value = '{KERNEL_ROW_W'(width_reg), KERNEL_ROW_W'(height_reg), top_reg, mid_reg,
                bot_reg};
      wait_idle();
      for (int i = 0; i < 5; i++) begin
         csr_we <= 1'b1;
         csr_index <= index[i];
         csr_wdata <= value[i];
         @(negedge clock);
      end
      csr_we <= 1'b0;
      cfg_width = width_reg;
      cfg_height = height_reg;
      cfg_kernel = '{top_reg, mid_reg, bot_reg};
   endtask

   // 1024 x 1024 out of reset gives nothing in the first row; then shrink the frame only,
   // so the reset kernel (identity) shapes the results
   task automatic test_reset_defaults();
      send_frame(16, 1'b1, 0, 255, 1'b0);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= REG_FRAME_WIDTH;
      csr_wdata <= KERNEL_ROW_W'(11'd6);
      @(negedge clock);
      csr_index <= REG_FRAME_HEIGHT;
      csr_wdata <= KERNEL_ROW_W'(11'd5);
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_width = 11'd6;
      cfg_height = 11'd5;
      send_frame(30, 1'b1, 0, 255, 1'b0);
   endtask

   task automatic test_kernel_extremes();
      apply_settings(11'd1, 11'd2, 24'h808080, 24'h808080, 24'h808080);
      send_frame(9, 1'b1, 255, 255, 1'b0);
      // second frame follows without a marker
      apply_settings(11'd2, 11'd0, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
      send_frame(9, 1'b0, 255, 255, 1'b0);
      send_frame(9, 1'b0, 0, 0, 1'b0);
      apply_settings(11'd3, 11'd3, 24'h00FF01, 24'h02FE03, 24'h7F0180);
      send_frame(9, 1'b0, 0, 3, 1'b0);
   endtask

   task automatic test_midframe_resize();
      apply_settings(11'd5, 11'd4, random_kernel_row(), random_kernel_row(),
                     random_kernel_row());
      send_frame(14, 1'b1, 0, 20, 1'b0);
      // shrink below the current column and row: one more result, then wrap
      apply_settings(11'd3, 11'd3, cfg_kernel[0], cfg_kernel[1], cfg_kernel[2]);
      send_frame(10, 1'b0, 0, 20, 1'b0);
   endtask

   // Oversized registers saturate to the upper limits: run the top rows of tall and wide
   // frames, where no early wrap or frame end may show
   task automatic test_largest_frames();
      apply_settings(11'd0, 11'h7FF, random_kernel_row(), random_kernel_row(),
                     random_kernel_row());
      send_frame(60, 1'b1, 0, 255, 1'b0);
      apply_settings(11'h7FF, 11'd1, random_kernel_row(), random_kernel_row(),
                     random_kernel_row());
      send_frame(30, 1'b1, 0, 255, 1'b0);
   endtask

   task automatic test_random_frames(input int unsigned sender_pct, receiver_pct);
      int unsigned start, w, h, frames, pixels, hi;
      logic [CFG_SIZE_W-1:0] width_reg, height_reg;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      start = pixels_accepted;
      while (pixels_accepted - start < PHASE_PIXELS) begin
         case ($urandom_range(9))
            0:       width_reg = CFG_SIZE_W'($urandom_range(2));
            1:       width_reg = CFG_SIZE_W'($urandom_range(40, 13));
            default: width_reg = CFG_SIZE_W'($urandom_range(12, 3));
         endcase
         case ($urandom_range(9))
            0:       height_reg = CFG_SIZE_W'($urandom_range(2));
            1:       height_reg = CFG_SIZE_W'($urandom_range(12, 7));
            default: height_reg = CFG_SIZE_W'($urandom_range(6, 3));
         endcase
         apply_settings(width_reg, height_reg, random_kernel_row(), random_kernel_row(),
                        random_kernel_row());
         w = frame_dim(width_reg, DEF_MAX_WIDTH);
         h = frame_dim(height_reg, DEF_MAX_HEIGHT);
         frames = $urandom_range(3, 1);
         // the first frame after a size change starts marked; later ones may just run on
         for (int f = 0; f < frames; f++) begin
            pixels = ($urandom_range(4) == 0) ? $urandom_range(w * h, 1) : w * h;
            hi = $urandom_range(1) ? 255 : 20;
            send_frame(pixels, f == 0 || $urandom_range(1), 0, hi, 1'b1);
         end
      end
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      rsp_item_type want, seen;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_item_type'({rsp_tlast, rsp_tdata[RSP_FIELD_W-1:0]});
         if (pixels_due.size() == 0) begin
            $error("result with none owed: pixel_out %0d, out_column %0d, out_row %0d",
                   seen.pixel, seen.column, seen.row);
            mismatch_count++;
         end else begin
            want = pixels_due.pop_front();
            if (seen.pixel !== want.pixel) begin
               $error("pixel_out: expected %0d, got %0d", want.pixel, seen.pixel);
               mismatch_count++;
            end
            if (seen.column !== want.column) begin
               $error("out_column: expected %0d, got %0d", want.column, seen.column);
               mismatch_count++;
            end
            if (seen.row !== want.row) begin
               $error("out_row: expected %0d, got %0d", want.row, seen.row);
               mismatch_count++;
            end
            if (seen.frame_end !== want.frame_end) begin
               $error("frame_end: expected %0d, got %0d", want.frame_end, seen.frame_end);
               mismatch_count++;
            end
            if (rsp_tdata[RSP_DATA_W-1:RSP_FIELD_W] !== '0) begin
               $error("padding: expected 0, got %0h", rsp_tdata[RSP_DATA_W-1:RSP_FIELD_W]);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_kernel_extremes();
      test_midframe_resize();
      test_largest_frames();
      test_random_frames(22, 72);
      test_random_frames(72, 22);
      test_random_frames(0, 0);
      wait_idle();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
